@@ sv/matrix_keypad_scanner_defines.svh @@
// assertion macros shared by the keypad scanner rtl
`ifndef MATRIX_KEYPAD_SCANNER_DEFINES_SVH
`define MATRIX_KEYPAD_SCANNER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define KPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keypad scanner check failed");

// next-cycle implication, checked outside reset
`define KPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypad scanner check failed");

`endif

@@ sv/kps_pkg.sv @@
// shared types, codes and key table of the keypad scanner
package kps_pkg;

    localparam int COL_W      = 4;
    localparam int ROW_W      = 4;
    localparam int STATUS_W   = 3;
    localparam int KEY_W      = 8;
    localparam int TIMEOUT_W  = 32;
    localparam int DEBOUNCE_W = 8;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 1'd1;

    // configuration reset values
    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_NO_LIMIT  = 32'hFFFF_FFFF;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_DEFAULT = 8'd20;

    // status codes
    localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_KEY_READY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ABORT     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FALSE_TRG = 3'd4;

    localparam logic [COL_W-1:0] COLS_IDLE = 4'hF;

    typedef struct packed {
        logic [COL_W-1:0] col_pins;
        logic             rtc_event;
    } in_item_t;

    typedef struct packed {
        logic [ROW_W-1:0]    row_drive;
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key_code;
    } result_t;

    // lowest column pulled low, zero when none is
    function automatic logic [1:0] lowest_low_col(input logic [COL_W-1:0] cols);
        logic [1:0] idx;
        idx = 2'd0;
        if (!cols[0])
            idx = 2'd0;
        else if (!cols[1])
            idx = 2'd1;
        else if (!cols[2])
            idx = 2'd2;
        else if (!cols[3])
            idx = 2'd3;
        return idx;
    endfunction

    // key legend, row major
    function automatic logic [KEY_W-1:0] key_ascii(input logic [3:0] idx);
        logic [KEY_W-1:0] code;
        unique case (idx)
            4'd0:    code = "1";
            4'd1:    code = "2";
            4'd2:    code = "3";
            4'd3:    code = "A";
            4'd4:    code = "4";
            4'd5:    code = "5";
            4'd6:    code = "6";
            4'd7:    code = "B";
            4'd8:    code = "7";
            4'd9:    code = "8";
            4'd10:   code = "9";
            4'd11:   code = "C";
            4'd12:   code = "*";
            4'd13:   code = "0";
            4'd14:   code = "#";
            default: code = "D";
        endcase
        return code;
    endfunction

endpackage

@@ sv/kps_if.sv @@
// valid/ready channel interfaces of the keypad scanner
interface kps_in_if;
    import kps_pkg::*;

    logic             valid;
    logic             ready;
    logic [COL_W-1:0] col_pins;
    logic             rtc_event;

    modport source (output valid, output col_pins, output rtc_event, input ready);
    modport sink   (input valid, input col_pins, input rtc_event, output ready);
endinterface

interface kps_out_if;
    import kps_pkg::*;

    logic                valid;
    logic                ready;
    logic [ROW_W-1:0]    row_drive;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key_code;

    modport source (output valid, output row_drive, output status, output key_code,
                    input ready);
    modport sink   (input valid, input row_drive, input status, input key_code,
                    output ready);
endinterface

@@ sv/matrix_keypad_scanner.sv @@
// keypad scanner top level: input register, step logic and result register
//
//   channel  dir  payload                        handshake
//   in_ch    in   col_pins, rtc_event            valid/ready
//   out_ch   out  row_drive, status, key_code    valid/ready
//   cfg      in   cfg_index, cfg_data            cfg_we, no wait
//
// one tick in, one result out; a tick enters the input register, the step
// logic runs on it once the result register is free and loads the result register
// throughput is one tick per cycle while out_ch takes results
// a stalled result holds the input register; in_ch.ready then drops
// rst_n clears both valid flags and the scan state and resets the configuration to its defaults
`include "matrix_keypad_scanner_defines.svh"

module matrix_keypad_scanner (
    input  logic                           clk,
    input  logic                           rst_n,
    kps_in_if.sink                         in_ch,
    kps_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [kps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kps_pkg::CFG_DATA_W-1:0] cfg_data
);
    import kps_pkg::*;

    logic     s1_valid_reg, s1_valid_next;
    in_item_t s1_item_reg;
    logic     out_valid_reg, out_valid_next;
    result_t  out_item_reg;
    result_t  step_result;
    in_item_t in_item;
    logic     in_fire;
    logic     s1_fire;

    // handshake control
    assign s1_fire     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_fire;
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign in_item.col_pins  = in_ch.col_pins;
    assign in_item.rtc_event = in_ch.rtc_event;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_fire)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_item_reg <= in_item;
        if (s1_fire)
            out_item_reg <= step_result;
    end

    // scan state machine
    kps_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step_en   (s1_fire),
        .item      (s1_item_reg),
        .result    (step_result)
    );

    // result channel
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.row_drive = out_item_reg.row_drive;
    assign out_ch.status    = out_item_reg.status;
    assign out_ch.key_code  = out_item_reg.key_code;

    // checks
    `KPS_ASSERT_NXT(a_stalled_tick_kept, clk, rst_n, s1_valid_reg && !s1_fire, s1_valid_reg)
    `KPS_ASSERT_IMP(a_key_only_when_ready, clk, rst_n, out_valid_reg && out_ch.key_code != 8'd0,
                    out_ch.status == ST_KEY_READY)
    `KPS_ASSERT_IMP(a_ready_has_key, clk, rst_n, out_valid_reg && out_ch.status == ST_KEY_READY,
                    out_ch.key_code != 8'd0)
    `KPS_ASSERT_IMP(a_outcome_grounds_rows, clk, rst_n, out_valid_reg && out_ch.status != ST_BUSY,
                    out_ch.row_drive == 4'h0)
    `KPS_ASSERT_IMP(a_single_row_scanned, clk, rst_n, out_valid_reg && out_ch.row_drive != 4'h0,
                    $countones(~out_ch.row_drive) == 1)

endmodule

@@ sv/kps_core.sv @@
// scanner state machine, configuration registers and per-tick step logic
module kps_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [kps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kps_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              step_en,
    input  kps_pkg::in_item_t                 item,
    output kps_pkg::result_t                  result
);
    import kps_pkg::*;

    localparam logic [2:0] PH_WAIT_PRESS = 3'd0;
    localparam logic [2:0] PH_DEB_PRESS  = 3'd1;
    localparam logic [2:0] PH_SCAN       = 3'd2;
    localparam logic [2:0] PH_WAIT_REL   = 3'd3;
    localparam logic [2:0] PH_DEB_REL    = 3'd4;

    logic [TIMEOUT_W-1:0]  timeout_limit_reg;
    logic [DEBOUNCE_W-1:0] debounce_ticks_reg;

    logic [2:0]            phase_reg, phase_next;
    logic [TIMEOUT_W-1:0]  wait_count_reg, wait_count_next;
    logic [DEBOUNCE_W-1:0] deb_count_reg, deb_count_next;
    logic [1:0]            row_reg, row_next;
    logic [3:0]            key_reg, key_next;

    logic                  pressed;
    logic [DEBOUNCE_W-1:0] deb_inc;
    logic                  deb_done;
    logic [TIMEOUT_W-1:0]  wait_inc;
    logic [2:0]            row_inc;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_limit_reg  <= TIMEOUT_NO_LIMIT;
            debounce_ticks_reg <= DEBOUNCE_DEFAULT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT_LIMIT:  timeout_limit_reg  <= cfg_data[TIMEOUT_W-1:0];
                CFG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_data[DEBOUNCE_W-1:0];
                default:            ;
            endcase
        end
    end

    // shared arithmetic
    assign pressed  = (item.col_pins != COLS_IDLE);
    assign deb_inc  = deb_count_reg + 8'd1;
    assign deb_done = (deb_inc >= debounce_ticks_reg);
    assign wait_inc = wait_count_reg + 32'd1;
    assign row_inc  = {1'b0, row_reg} + 3'd1;

    // one tick of the scanner
    always_comb
    begin
        phase_next      = phase_reg;
        wait_count_next = wait_count_reg;
        deb_count_next  = deb_count_reg;
        row_next        = row_reg;
        key_next        = key_reg;
        result.row_drive = '0;
        result.status    = ST_BUSY;
        result.key_code  = '0;

        unique case (phase_reg)
            PH_DEB_PRESS:
            begin
                deb_count_next = deb_inc;
                if (deb_done)
                begin
                    if (!pressed)
                    begin
                        result.status = ST_FALSE_TRG;
                        phase_next    = PH_WAIT_PRESS;
                    end
                    else
                    begin
                        row_next         = 2'd0;
                        result.row_drive = 4'hE;
                        phase_next       = PH_SCAN;
                    end
                end
            end
            PH_SCAN:
            begin
                if (pressed)
                begin
                    key_next   = {row_reg, lowest_low_col(item.col_pins)};
                    phase_next = PH_WAIT_REL;
                end
                else if (row_inc[2])
                begin
                    // no row answered
                    result.status = ST_FALSE_TRG;
                    row_next      = 2'd0;
                    phase_next    = PH_WAIT_PRESS;
                end
                else
                begin
                    row_next         = row_inc[1:0];
                    result.row_drive = ~(4'b0001 << row_inc[1:0]);
                end
            end
            PH_WAIT_REL:
            begin
                if (!pressed)
                begin
                    deb_count_next = '0;
                    phase_next     = PH_DEB_REL;
                end
            end
            PH_DEB_REL:
            begin
                deb_count_next = deb_inc;
                if (deb_done)
                begin
                    result.status   = ST_KEY_READY;
                    result.key_code = key_ascii(key_reg);
                    phase_next      = PH_WAIT_PRESS;
                end
            end
            default:
            begin
                // press wait, also taken for unused phase codes
                phase_next = PH_WAIT_PRESS;
                if (pressed)
                begin
                    wait_count_next = '0;
                    deb_count_next  = '0;
                    phase_next      = PH_DEB_PRESS;
                end
                else if (item.rtc_event)
                begin
                    wait_count_next = '0;
                    result.status   = ST_ABORT;
                end
                else if (timeout_limit_reg != TIMEOUT_NO_LIMIT)
                begin
                    if (wait_inc >= timeout_limit_reg)
                    begin
                        wait_count_next = '0;
                        result.status   = ST_TIMEOUT;
                    end
                    else
                    begin
                        wait_count_next = wait_inc;
                    end
                end
            end
        endcase
    end

    // state registers, advanced once per processed tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_WAIT_PRESS;
            wait_count_reg <= '0;
            deb_count_reg  <= '0;
            row_reg        <= '0;
            key_reg        <= '0;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            wait_count_reg <= wait_count_next;
            deb_count_reg  <= deb_count_next;
            row_reg        <= row_next;
            key_reg        <= key_next;
        end
    end

endmodule
